// ----- hdl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the RSI core
// Holds the widths, the register reset value, the controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Defaults for the top-level parameters
  localparam int PRICE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_PERIOD_DEF = 255;

  // Period register
  localparam int                      PERIOD_BITS  = 8;
  localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET = 8'd14;

  // Smoothed averages are kept modulo 2^64
  localparam int AVG_BITS = 64;

  // RSI in hundredths: 100.0 scaled by 100
  localparam int                   RSI_BITS  = 14;
  localparam logic [RSI_BITS-1:0]  RSI_SCALE = 14'd10000;
  localparam logic [RSI_BITS-1:0]  RSI_FULL  = 14'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHANGE,
    ST_BRANCH,
    ST_GAIN_START,
    ST_GAIN_WAIT,
    ST_LOSS_START,
    ST_LOSS_WAIT,
    ST_RSI_CHECK,
    ST_RSI_WAIT,
    ST_EMIT_NONE,
    ST_EMIT_FULL,
    ST_EMIT_QUOT
  } state_t;

  typedef enum logic [1:0] {
    DIV_GAIN,
    DIV_LOSS,
    DIV_RSI
  } div_sel_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_FULL,
    RES_QUOT
  } res_kind_t;

  typedef struct packed {
    logic      take;
    logic      change;
    logic      branch;
    logic      div_start;
    div_sel_t  div_sel;
    logic      wr_gain;
    logic      wr_loss;
    logic      res_write;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic series_start;
    logic warm;
    logic warm_done;
    logic loss_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/rsi_div.sv -----
// ----------------------------------------------------------------------------
// rsi_div: iterative restoring divider
// One quotient bit per cycle. The caller preloads the partial remainder and
// the numerator bits still to be shifted in, so short quotients skip the
// leading steps. Only the low QUO_W quotient bits are kept.
// ----------------------------------------------------------------------------
module rsi_div #(
  parameter int  NUM_W = 80,
  parameter int  DEN_W = 65,
  parameter int  QUO_W = 64,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] rem_init,
  input  logic [NUM_W-1:0] num_init,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] steps,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, num[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      num   <= num_init;
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      // the remainder stays below the divisor, so the top trial bit drops
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num <= num << 1;
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

// ----- hdl/rsi_dp.sv -----
// ----------------------------------------------------------------------------
// rsi_dp: RSI datapath
// Series state (previous price, warm-up count, gain/loss averages), the
// period register, operand setup for the shared divider and the output
// register.
// ----------------------------------------------------------------------------
module rsi_dp #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF,
  parameter int MAX_PERIOD = rsi_pkg::MAX_PERIOD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rsi_pkg::dp_cmd_t                 cmd,
  output rsi_pkg::dp_status_t              status,
  input  logic [PRICE_BITS-1:0]            price,
  input  logic                             series_start,
  input  logic                             cfg_valid,
  input  logic [rsi_pkg::PERIOD_BITS-1:0]  cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [rsi_pkg::RSI_BITS-1:0]     rsi_hundredths,
  output logic                             rsi_valid
);

  localparam int AW     = rsi_pkg::AVG_BITS;
  localparam int PW     = rsi_pkg::PERIOD_BITS;
  localparam int RB     = rsi_pkg::RSI_BITS;
  localparam int PROD_W = AW + PW;
  localparam int RSI_W  = AW + RB;
  localparam int FIRST_W = AW + FRAC_BITS;
  localparam int WIL_W  = PROD_W + 1;
  localparam int NUM_A  = (FIRST_W > WIL_W) ? FIRST_W : WIL_W;
  localparam int NUM_W  = (NUM_A > RSI_W) ? NUM_A : RSI_W;
  localparam int DEN_W  = AW + 1;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int PCAP_I = (MAX_PERIOD < (1 << PW) - 1) ? MAX_PERIOD : (1 << PW) - 1;
  localparam logic [PW-1:0] PCAP = PW'(PCAP_I);

  logic [PW-1:0]         period_reg;
  logic [PW-1:0]         p_act;
  logic [PW-1:0]         pm1;
  logic [PRICE_BITS-1:0] price_q;
  logic                  start_q;
  logic [PRICE_BITS-1:0] prev;
  logic [PRICE_BITS-1:0] gx;
  logic [PRICE_BITS-1:0] lx;
  logic [PW-1:0]         count;
  logic [AW-1:0]         gain_avg;
  logic [AW-1:0]         loss_avg;
  logic                  first;

  logic [AW-1:0]         sel_avg;
  logic [PRICE_BITS-1:0] sel_x;
  logic [PROD_W-1:0]     prod;
  logic [RSI_W-1:0]      n_rsi;
  logic [DEN_W-1:0]      div_rem_init;
  logic [NUM_W-1:0]      div_num_init;
  logic [DEN_W-1:0]      div_den;
  logic [CNT_W-1:0]      div_steps;
  logic                  div_busy;
  logic                  div_done;
  logic [AW-1:0]         div_quo;

  // zero period acts as one, large periods are capped
  always_comb begin
    if (period_reg == '0) begin
      p_act = PW'(1);
    end else if (int'(period_reg) > PCAP_I) begin
      p_act = PCAP;
    end else begin
      p_act = period_reg;
    end
  end

  assign pm1 = p_act - PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg <= rsi_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      period_reg <= cfg_data;
    end
  end

  // series state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_q  <= 1'b0;
      first    <= 1'b0;
      prev     <= '0;
      count    <= '0;
      gain_avg <= '0;
      loss_avg <= '0;
    end else begin
      if (cmd.take) begin
        start_q <= series_start;
      end
      if (cmd.change) begin
        prev <= price_q;
        if (start_q) begin
          count    <= '0;
          gain_avg <= '0;
          loss_avg <= '0;
        end
      end
      if (cmd.branch) begin
        first <= status.warm;
        if (status.warm) begin
          gain_avg <= gain_avg + AW'(gx);
          loss_avg <= loss_avg + AW'(lx);
          count    <= count + PW'(1);
        end
      end
      if (cmd.wr_gain) begin
        gain_avg <= div_quo;
      end
      if (cmd.wr_loss) begin
        loss_avg <= div_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      price_q <= price;
    end
    if (cmd.change) begin
      // a flat price counts as a zero loss
      if (price_q > prev) begin
        gx <= price_q - prev;
        lx <= '0;
      end else begin
        gx <= '0;
        lx <= prev - price_q;
      end
    end
  end

  // divider operands
  assign sel_avg = (cmd.div_sel == rsi_pkg::DIV_LOSS) ? loss_avg : gain_avg;
  assign sel_x   = (cmd.div_sel == rsi_pkg::DIV_LOSS) ? lx : gx;
  assign prod    = PROD_W'(sel_avg) * PROD_W'(pm1);
  assign n_rsi   = RSI_W'(gain_avg) * RSI_W'(rsi_pkg::RSI_SCALE);

  always_comb begin
    unique case (cmd.div_sel) inside
      rsi_pkg::DIV_GAIN, rsi_pkg::DIV_LOSS: begin
        div_rem_init = '0;
        div_den      = DEN_W'(p_act);
        div_steps    = CNT_W'(NUM_W);
        if (first) begin
          div_num_init = NUM_W'(sel_avg) << FRAC_BITS;
        end else begin
          div_num_init = NUM_W'(prod) + (NUM_W'(sel_x) << FRAC_BITS);
        end
      end
      rsi_pkg::DIV_RSI: begin
        // quotient fits in RSI_BITS, so start with the upper bits preloaded
        div_rem_init = DEN_W'(n_rsi[RSI_W-1:RB]);
        div_num_init = NUM_W'(n_rsi[RB-1:0]) << (NUM_W - RB);
        div_den      = {1'b0, gain_avg} + {1'b0, loss_avg};
        div_steps    = CNT_W'(RB);
      end
      default: begin
        div_rem_init = '0;
        div_num_init = '0;
        div_den      = DEN_W'(1);
        div_steps    = CNT_W'(1);
      end
    endcase
  end

  rsi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .den      (div_den),
    .steps    (div_steps),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      case (cmd.res_kind)
        rsi_pkg::RES_FULL: begin
          rsi_hundredths <= rsi_pkg::RSI_FULL;
          rsi_valid      <= 1'b1;
        end
        rsi_pkg::RES_QUOT: begin
          rsi_hundredths <= div_quo[RB-1:0];
          rsi_valid      <= 1'b1;
        end
        default: begin
          rsi_hundredths <= '0;
          rsi_valid      <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    status.series_start = start_q;
    status.warm         = (count < p_act);
    status.warm_done    = (({1'b0, count} + (PW + 1)'(1)) >= {1'b0, p_act});
    status.loss_zero    = (loss_avg == '0);
    status.div_busy     = div_busy;
    status.div_done     = div_done;
    status.out_free     = !out_valid || out_ready;
  end

endmodule

// ----- hdl/rsi_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsi_ctrl: RSI sequencer
// Steps one price sample through change, warm-up or smoothing, the two
// average divisions, the RSI division and the output register write.
// ----------------------------------------------------------------------------
module rsi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsi_pkg::dp_status_t status,
  output rsi_pkg::dp_cmd_t    cmd
);

  rsi_pkg::state_t state;
  rsi_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      rsi_pkg::ST_IDLE: begin
        if (in_valid) state_next = rsi_pkg::ST_CHANGE;
      end
      rsi_pkg::ST_CHANGE: begin
        state_next = status.series_start ? rsi_pkg::ST_EMIT_NONE : rsi_pkg::ST_BRANCH;
      end
      rsi_pkg::ST_BRANCH: begin
        // still warming up after this change: no average to form yet
        if (status.warm && !status.warm_done) begin
          state_next = rsi_pkg::ST_EMIT_NONE;
        end else begin
          state_next = rsi_pkg::ST_GAIN_START;
        end
      end
      rsi_pkg::ST_GAIN_START: state_next = rsi_pkg::ST_GAIN_WAIT;
      rsi_pkg::ST_GAIN_WAIT: begin
        if (status.div_done) state_next = rsi_pkg::ST_LOSS_START;
      end
      rsi_pkg::ST_LOSS_START: state_next = rsi_pkg::ST_LOSS_WAIT;
      rsi_pkg::ST_LOSS_WAIT: begin
        if (status.div_done) state_next = rsi_pkg::ST_RSI_CHECK;
      end
      rsi_pkg::ST_RSI_CHECK: begin
        state_next = status.loss_zero ? rsi_pkg::ST_EMIT_FULL : rsi_pkg::ST_RSI_WAIT;
      end
      rsi_pkg::ST_RSI_WAIT: begin
        if (status.div_done) state_next = rsi_pkg::ST_EMIT_QUOT;
      end
      rsi_pkg::ST_EMIT_NONE, rsi_pkg::ST_EMIT_FULL, rsi_pkg::ST_EMIT_QUOT: begin
        if (status.out_free) state_next = rsi_pkg::ST_IDLE;
      end
      default: state_next = rsi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.change    = 1'b0;
    cmd.branch    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = rsi_pkg::DIV_GAIN;
    cmd.wr_gain   = 1'b0;
    cmd.wr_loss   = 1'b0;
    cmd.res_write = 1'b0;
    cmd.res_kind  = rsi_pkg::RES_NONE;
    unique case (state)
      rsi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      rsi_pkg::ST_CHANGE: cmd.change = 1'b1;
      rsi_pkg::ST_BRANCH: cmd.branch = 1'b1;
      rsi_pkg::ST_GAIN_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rsi_pkg::DIV_GAIN;
      end
      rsi_pkg::ST_GAIN_WAIT: cmd.wr_gain = status.div_done;
      rsi_pkg::ST_LOSS_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rsi_pkg::DIV_LOSS;
      end
      rsi_pkg::ST_LOSS_WAIT: cmd.wr_loss = status.div_done;
      rsi_pkg::ST_RSI_CHECK: begin
        cmd.div_start = !status.loss_zero;
        cmd.div_sel   = rsi_pkg::DIV_RSI;
      end
      rsi_pkg::ST_RSI_WAIT: cmd.div_sel = rsi_pkg::DIV_RSI;
      rsi_pkg::ST_EMIT_NONE: begin
        cmd.res_write = status.out_free;
        cmd.res_kind  = rsi_pkg::RES_NONE;
      end
      rsi_pkg::ST_EMIT_FULL: begin
        cmd.res_write = status.out_free;
        cmd.res_kind  = rsi_pkg::RES_FULL;
      end
      rsi_pkg::ST_EMIT_QUOT: begin
        cmd.res_write = status.out_free;
        cmd.res_kind  = rsi_pkg::RES_QUOT;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/relative_strength_index_core.sv -----
// ----------------------------------------------------------------------------
// relative_strength_index_core: Wilder RSI over a stream of price samples
// Input channel (in_valid/in_ready) carries price and series_start; output
// channel (out_valid/out_ready) carries rsi_hundredths and rsi_valid, one
// result transaction per input transaction, in order.
// Configuration channel (cfg_valid/cfg_ready) writes period_length; it is
// always ready and should be written only while the core is idle.
// Sequence: a series start goes from ST_CHANGE straight to ST_EMIT_NONE, a
// warm-up sample through ST_CHANGE, ST_BRANCH and ST_EMIT_NONE. A sample that
// forms or smooths the averages runs three divisions on one shared
// one-bit-per-cycle divider: two of NUM_W steps (NUM_W = 64 + max(FRAC_BITS,
// 14), 80 at defaults) and one of 14 steps; a zero average loss skips the RSI
// division. One sample is in work at a time; the next is taken once its
// result has been written to the output register.
// The output register lets a new sample be taken while the last result is
// still waiting; a stalled receiver blocks the core only when the next
// result is ready to be written.
// Reset: period_length returns to 14, the series state clears (previous
// price zero), and both channels go empty.
// ----------------------------------------------------------------------------
module relative_strength_index_core #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF,
  parameter int MAX_PERIOD = rsi_pkg::MAX_PERIOD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PRICE_BITS-1:0]            price,
  input  logic                             series_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rsi_pkg::RSI_BITS-1:0]     rsi_hundredths,
  output logic                             rsi_valid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsi_pkg::PERIOD_BITS-1:0]  period_length
);

  rsi_pkg::dp_cmd_t    cmd;
  rsi_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  rsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rsi_dp #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_PERIOD (MAX_PERIOD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .price          (price),
    .series_start   (series_start),
    .cfg_valid      (cfg_valid),
    .cfg_data       (period_length),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .rsi_hundredths (rsi_hundredths),
    .rsi_valid      (rsi_valid)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_write |-> (!out_valid || out_ready))
    else $error("result written over a pending transaction");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rsi_hundredths <= rsi_pkg::RSI_FULL))
    else $error("RSI above full scale");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsi_valid) |-> (rsi_hundredths == '0))
    else $error("invalid result carries a nonzero RSI");

endmodule

// ----- dv/tb_relative_strength_index_core.sv -----
// ----------------------------------------------------------------------------
// tb_relative_strength_index_core: self-checking bench for the Wilder RSI core
// Drives price samples and period writes through valid/ready channels with
// random idle gaps on both sides. It predicts every result with a local
// model of the warm-up sums, the Wilder smoothing and the exact RSI division,
// and compares each result transaction with the oldest prediction.
// A directed table comes first, then random series at several periods.
// ----------------------------------------------------------------------------
module tb_relative_strength_index_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC           = rsi_pkg::FRAC_BITS_DEF;
  localparam int RB             = rsi_pkg::RSI_BITS;
  localparam int PB             = rsi_pkg::PERIOD_BITS;
  localparam int PMAX           = rsi_pkg::MAX_PERIOD_DEF;
  localparam int RAND_ITEMS     = 1100;
  localparam int STALL_LIMIT    = 6000;
  localparam int SQUEEZE_CYCLES = 700;
  localparam int DRAIN_CYCLES   = 250;
  localparam int DIR_ROWS       = 28;

  typedef struct packed {
    logic [RB-1:0] rsi;
    logic          valid;
  } rsi_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [31:0]   px;
    logic          start;
    logic          pinned;
    logic [RB-1:0] pin_rsi;
    logic          pin_valid;
    logic [7:0]    period;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            price = '0;
  logic                   series_start = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [RB-1:0]          rsi_hundredths;
  logic                   rsi_valid;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [PB-1:0]          period_length = '0;

  // Typed expectation travels alongside the payload of a directed row
  logic                   pin_exp = 1'b0;
  logic [RB-1:0]          pin_rsi = '0;
  logic                   pin_valid = 1'b0;

  // Predictor state
  logic [PB-1:0]          period_reg;
  logic [31:0]            prev_px;
  int                     changes_n;
  logic [63:0]            gain_avg;
  logic [63:0]            loss_avg;

  rsi_result_t            expected_rsi_q[$];
  int                     errors = 0;
  int                     samples_sent = 0;
  int                     random_items = 0;
  int                     results_seen = 0;
  int                     valid_results = 0;
  int                     period_writes = 0;
  int                     stall_cycles = 0;
  bit                     squeeze_req = 1'b0;

  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    // reset period 14: first sample is a change from zero, then a start
    '{ROW_ITEM, 32'd100,        1'b0, 1'b1, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b1, 1'b1, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd0,          1'b0, 1'b1, 14'd0,             1'b0, 8'd0},
    // period 1: every change forms the averages at once
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 14'd0,             1'b0, 8'd1},
    '{ROW_ITEM, 32'd50,         1'b1, 1'b1, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd60,         1'b0, 1'b1, rsi_pkg::RSI_FULL, 1'b1, 8'd0},
    '{ROW_ITEM, 32'd60,         1'b0, 1'b1, rsi_pkg::RSI_FULL, 1'b1, 8'd0},
    '{ROW_ITEM, 32'd0,          1'b0, 1'b1, 14'd0,             1'b1, 8'd0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b0, 1'b1, rsi_pkg::RSI_FULL, 1'b1, 8'd0},
    '{ROW_ITEM, 32'd0,          1'b0, 1'b1, 14'd0,             1'b1, 8'd0},
    // period 0 acts as 1
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd7,          1'b1, 1'b1, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd8,          1'b0, 1'b1, rsi_pkg::RSI_FULL, 1'b1, 8'd0},
    '{ROW_ITEM, 32'd7,          1'b0, 1'b1, 14'd0,             1'b1, 8'd0},
    // lower the period mid warm-up, then raise it after warm-up
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 14'd0,             1'b0, 8'd4},
    '{ROW_ITEM, 32'd1000,       1'b1, 1'b1, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd1300,       1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd1200,       1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd1250,       1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 14'd0,             1'b0, 8'd2},
    '{ROW_ITEM, 32'd1100,       1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd1150,       1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 14'd0,             1'b0, 8'd5},
    '{ROW_ITEM, 32'd1400,       1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd900,        1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_ITEM, 32'd950,        1'b0, 1'b0, 14'd0,             1'b0, 8'd0},
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 14'd0,             1'b0, 8'd255},
    '{ROW_ITEM, 32'd12345,      1'b0, 1'b0, 14'd0,             1'b0, 8'd0}
  };

  relative_strength_index_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .price          (price),
    .series_start   (series_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rsi_hundredths (rsi_hundredths),
    .rsi_valid      (rsi_valid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .period_length  (period_length)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int effective_period(input logic [PB-1:0] v);
    int p;
    p = int'(v);
    if (p == 0) p = 1;
    if (p > PMAX) p = PMAX;
    return p;
  endfunction

  // floor(sum * 2^FRAC / p), wrapping at 64 bits
  function automatic logic [63:0] seed_average(input logic [63:0] sum, input int p);
    logic [63:0] d, q, r;
    d = 64'(p);
    q = sum / d;
    r = sum % d;
    return (q << FRAC) + ((r << FRAC) / d);
  endfunction

  // floor((avg*(p-1) + x*2^FRAC) / p), split so no term overflows
  function automatic logic [63:0] wilder_smooth(input logic [63:0] avg, input logic [63:0] x,
                                                input int p);
    logic [63:0] d, m, big, q, r, s, t;
    d   = 64'(p);
    m   = d - 64'd1;
    big = x << FRAC;
    q   = avg / d;
    r   = avg % d;
    s   = big / d;
    t   = big % d;
    return q * m + s + (r * m + t) / d;
  endfunction

  function automatic logic [RB-1:0] rsi_from(input logic [63:0] g, input logic [63:0] l);
    logic [127:0] num, den, quo;
    if (l == 64'd0) return rsi_pkg::RSI_FULL;
    num = {64'd0, g} * 128'(rsi_pkg::RSI_SCALE);
    den = {64'd0, g} + {64'd0, l};
    quo = num / den;
    return quo[RB-1:0];
  endfunction

  function automatic rsi_result_t advance_rsi(input logic [31:0] px, input logic st);
    logic [63:0] gx, lx;
    int          p;
    rsi_result_t r;
    gx = '0;
    lx = '0;
    p = effective_period(period_reg);
    r.rsi = '0;
    r.valid = 1'b0;
    if (st) begin
      prev_px = px;
      changes_n = 0;
      gain_avg = '0;
      loss_avg = '0;
      return r;
    end
    if (px > prev_px) gx = {32'd0, px - prev_px};
    else lx = {32'd0, prev_px - px};
    prev_px = px;
    if (changes_n < p) begin
      gain_avg = gain_avg + gx;
      loss_avg = loss_avg + lx;
      changes_n++;
      if (changes_n >= p) begin
        gain_avg = seed_average(gain_avg, p);
        loss_avg = seed_average(loss_avg, p);
      end
    end else begin
      gain_avg = wilder_smooth(gain_avg, gx, p);
      loss_avg = wilder_smooth(loss_avg, lx, p);
    end
    if (changes_n >= p) begin
      r.rsi = rsi_from(gain_avg, loss_avg);
      r.valid = 1'b1;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    rsi_result_t want;
    if (rst) begin
      period_reg = rsi_pkg::PERIOD_RESET;
      prev_px = '0;
      changes_n = 0;
      gain_avg = '0;
      loss_avg = '0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (rsi_valid) valid_results++;
        if (expected_rsi_q.size() == 0) begin
          report_mismatch("result with nothing pending, rsi_hundredths", rsi_hundredths, -1);
        end else begin
          want = expected_rsi_q.pop_front();
          if (rsi_hundredths !== want.rsi)
            report_mismatch("rsi_hundredths", rsi_hundredths, want.rsi);
          if (rsi_valid !== want.valid)
            report_mismatch("rsi_valid", rsi_valid, want.valid);
        end
      end
      if (cfg_valid && cfg_ready) period_reg = period_length;
      if (in_valid && in_ready) begin
        want = advance_rsi(price, series_start);
        if (pin_exp) want = '{pin_rsi, pin_valid};
        expected_rsi_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 stall_cycles, expected_rsi_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  task automatic offer_sample(input logic [31:0] px, input logic st, input logic pe,
                              input logic [RB-1:0] pr, input logic pv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    price        <= px;
    series_start <= st;
    pin_exp      <= pe;
    pin_rsi      <= pr;
    pin_valid    <= pv;
    do @(posedge clk); while (!(in_valid && in_ready));
    samples_sent++;
  endtask

  // Write only once every pending result has come out
  task automatic write_period(input logic [PB-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsi_q.size() != 0) @(posedge clk);
    cfg_valid     <= 1'b1;
    period_length <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    period_writes++;
  endtask

  // Trending walk with random step scale; a little noise and stray starts
  task automatic random_series(input int len);
    logic [31:0] px, mask;
    logic        st;
    int          up_pct, k, r;
    px = $urandom;
    up_pct = $urandom_range(10, 90);
    k = $urandom_range(0, 32);
    mask = (k == 32) ? 32'hFFFF_FFFF : ((32'h1 << k) - 32'h1);
    for (int i = 0; i < len; i++) begin
      st = (i == 0) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 2);
      r = $urandom_range(0, 99);
      if (r < 5) px = $urandom;
      else if (r < 10) px = px;
      else if ($urandom_range(0, 99) < up_pct) px = px + ($urandom & mask);
      else px = px - ($urandom & mask);
      offer_sample(px, st, 1'b0, '0, 1'b0);
      random_items++;
    end
  endtask

  initial begin : receiver
    int  gap;
    bit  squeezed;
    squeezed = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        gap = SQUEEZE_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    int p, n, len, phase, r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) write_period(dir_tab[i].period);
      else offer_sample(dir_tab[i].px, dir_tab[i].start, dir_tab[i].pinned,
                        dir_tab[i].pin_rsi, dir_tab[i].pin_valid);
    end

    phase = 0;
    while (random_items < RAND_ITEMS) begin
      if (phase == 2) begin
        p = PMAX;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) p = 0;
        else if (r == 1) p = $urandom_range(9, 40);
        else p = $urandom_range(1, 8);
      end
      write_period(PB'(p));
      // long warm-up phase: stall the receiver while samples keep coming
      if (phase == 2) squeeze_req = 1'b1;
      n = (phase == 2) ? 300 : effective_period(PB'(p)) + $urandom_range(20, 70);
      while (n > 0) begin
        len = effective_period(PB'(p)) + $urandom_range(5, 40);
        if (len > n) len = n;
        random_series(len);
        n -= len;
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsi_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsi_q.size() != 0)
      report_mismatch("results never delivered", expected_rsi_q.size(), 0);

    $display("ran %0d samples (%0d random) in %0d phases, %0d period writes",
             samples_sent, random_items, phase, period_writes);
    $display("checked %0d results, %0d past warm-up; periods included 0, 1 and 255",
             results_seen, valid_results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
